// File: rtl/ocs_pkg.sv
// Shared types, constants and the control store of the occupation state counter.
// Depends on nothing; every other file of the block imports it.
package ocs_pkg;

  localparam int unsigned MaxSitesDef = 32;
  localparam int unsigned SiteW       = 6;
  localparam int unsigned DataW       = 64;
  localparam int unsigned TermW       = 2;
  localparam int unsigned PcW         = 4;
  localparam int unsigned ApbAddrW    = 3;
  localparam int unsigned ApbDataW    = 32;

  // Register addresses (word index taken from paddr[2])
  localparam logic RegSiteCount = 1'b0;

  // Input word
  typedef struct packed {
    logic [SiteW-1:0] double_count;
    logic [SiteW-1:0] up_count;
    logic [SiteW-1:0] down_count;
  } ocs_in_t;

  // Result word
  typedef struct packed {
    logic [DataW-1:0] state_count;
    logic             too_few_electrons;
  } ocs_out_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_INIT,
    OP_LOAD,
    OP_MUL,
    OP_QUOT,
    OP_NEXTK,
    OP_EMIT,
    OP_EMIT_ZERO,
    OP_EMIT_FLAG
  } ocs_op_e;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_FEW,
    C_BIG,
    C_RGTN,
    C_IDONE,
    C_DBUSY,
    C_MORE,
    C_END
  } ocs_cond_e;

  typedef struct packed {
    ocs_op_e          op;
    ocs_cond_e        cond;
    logic [PcW-1:0]   target;
  } ocs_word_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic few;
    logic big;
    logic r_gt_n;
    logic i_done;
    logic div_busy;
    logic more;
  } ocs_stat_t;

  // Program step addresses
  localparam logic [PcW-1:0] P_CHK_FEW = 4'd0;
  localparam logic [PcW-1:0] P_CHK_BIG = 4'd1;
  localparam logic [PcW-1:0] P_LOAD    = 4'd2;
  localparam logic [PcW-1:0] P_TEST    = 4'd3;
  localparam logic [PcW-1:0] P_MUL     = 4'd4;
  localparam logic [PcW-1:0] P_DIV     = 4'd5;
  localparam logic [PcW-1:0] P_STEP    = 4'd6;
  localparam logic [PcW-1:0] P_NEXT    = 4'd7;
  localparam logic [PcW-1:0] P_DONE    = 4'd8;
  localparam logic [PcW-1:0] P_ZERO    = 4'd9;
  localparam logic [PcW-1:0] P_FLAG    = 4'd10;

  // Control store: one word per step
  function automatic ocs_word_t ucode(input logic [PcW-1:0] pc);
    ocs_word_t w;
    w = '{op: OP_NOP, cond: C_END, target: P_CHK_FEW};
    case (pc)
      P_CHK_FEW: w = '{op: OP_NOP,       cond: C_FEW,    target: P_FLAG};
      P_CHK_BIG: w = '{op: OP_INIT,      cond: C_BIG,    target: P_ZERO};
      P_LOAD:    w = '{op: OP_LOAD,      cond: C_RGTN,   target: P_ZERO};
      P_TEST:    w = '{op: OP_NOP,       cond: C_IDONE,  target: P_NEXT};
      P_MUL:     w = '{op: OP_MUL,       cond: C_NEVER,  target: P_CHK_FEW};
      P_DIV:     w = '{op: OP_NOP,       cond: C_DBUSY,  target: P_DIV};
      P_STEP:    w = '{op: OP_QUOT,      cond: C_ALWAYS, target: P_TEST};
      P_NEXT:    w = '{op: OP_NEXTK,     cond: C_MORE,   target: P_LOAD};
      P_DONE:    w = '{op: OP_EMIT,      cond: C_END,    target: P_CHK_FEW};
      P_ZERO:    w = '{op: OP_EMIT_ZERO, cond: C_END,    target: P_CHK_FEW};
      P_FLAG:    w = '{op: OP_EMIT_FLAG, cond: C_END,    target: P_CHK_FEW};
      default:   w = '{op: OP_NOP,       cond: C_END,    target: P_CHK_FEW};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/ocs_div.sv
// Restoring bit-serial divider: wide dividend by a narrow divisor, one quotient bit a cycle.
// Depends on ocs_pkg for default widths.
module ocs_div #(
  parameter int unsigned DataW = ocs_pkg::DataW,
  parameter int unsigned DivW  = ocs_pkg::SiteW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DivW-1:0]  divisor_i,
  output logic             busy_o,
  output logic [DataW-1:0] quot_o
);
  import ocs_pkg::*;

  localparam int unsigned CntW = $clog2(DataW);

  logic             busy_q, busy_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DivW-1:0]  rem_q, rem_d;
  logic [DivW-1:0]  dvs_q, dvs_d;
  logic [DivW:0]    trial;
  logic             fits;

  // Shift in the next dividend bit and try to subtract
  assign trial = {rem_q, quo_q[DataW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DataW - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DataW-2:0], fits};
      rem_d = fits ? DivW'(trial - {1'b0, dvs_q}) : trial[DivW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  // Hold control under reset; payload needs none
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

// File: rtl/ocs_dpath.sv
// Datapath: accumulator, term selection, factor counter, multiplier and result register.
// Depends on ocs_pkg and ocs_div.
module ocs_dpath #(
  parameter int unsigned MAX_SITES = ocs_pkg::MaxSitesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  ocs_pkg::ocs_in_t             cmd_i,
  input  logic [ocs_pkg::SiteW-1:0]    site_count_i,
  input  ocs_pkg::ocs_op_e             op_i,
  output ocs_pkg::ocs_stat_t           stat_o,
  output logic                         res_valid_o,
  output ocs_pkg::ocs_out_t            res_o
);
  import ocs_pkg::*;

  localparam logic [SiteW-1:0] MaxS = SiteW'(MAX_SITES);

  ocs_in_t          cmd_q;
  logic [DataW-1:0] acc_q;
  logic [TermW-1:0] k_q;
  logic [SiteW-1:0] n_q, rr_q, i_q;
  logic             res_valid_q;
  ocs_out_t         res_q;

  logic [SiteW-1:0]       s, n_t, r_t, nr_t, fac;
  logic [DataW+SiteW-1:0] prod;
  logic                   div_start, div_busy;
  logic [DataW-1:0]       div_quot;

  // Saturate the site count
  assign s = (site_count_i > MaxS) ? MaxS : site_count_i;

  // Pick n and r of the current binomial term
  always_comb begin
    case (k_q)
      2'd0: begin
        n_t = s;
        r_t = cmd_q.double_count;
      end
      2'd1: begin
        n_t = s - cmd_q.double_count;
        r_t = cmd_q.up_count - cmd_q.double_count;
      end
      default: begin
        n_t = s - cmd_q.up_count;
        r_t = cmd_q.down_count - cmd_q.double_count;
      end
    endcase
  end
  assign nr_t = n_t - r_t;

  // Next factor of the product and the multiply
  assign fac  = SiteW'(n_q + 1'b1 - i_q);
  assign prod = acc_q * fac;
  assign div_start = (op_i == OP_MUL);

  ocs_div #(
    .DataW(DataW),
    .DivW (SiteW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(prod[DataW-1:0]),
    .divisor_i (i_q),
    .busy_o    (div_busy),
    .quot_o    (div_quot)
  );

  // Status for jump conditions
  always_comb begin
    stat_o.few      = (cmd_q.up_count < cmd_q.double_count) ||
                      (cmd_q.down_count < cmd_q.double_count);
    stat_o.big      = (cmd_q.double_count > s) || (cmd_q.up_count > s);
    stat_o.r_gt_n   = r_t > n_t;
    stat_o.i_done   = i_q > rr_q;
    stat_o.div_busy = div_busy;
    stat_o.more     = k_q != 2'd2;
  end

  // Capture the command word
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      cmd_q <= cmd_i;
    end
  end

  // Execute the current operation
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_INIT: begin
        acc_q <= DataW'(1);
        k_q   <= '0;
      end
      OP_LOAD: begin
        n_q  <= n_t;
        rr_q <= (r_t > nr_t) ? nr_t : r_t;
        i_q  <= SiteW'(1);
      end
      OP_QUOT: begin
        acc_q <= div_quot;
        i_q   <= i_q + 1'b1;
      end
      OP_NEXTK: begin
        k_q <= k_q + 1'b1;
      end
      OP_EMIT: begin
        res_q <= '{state_count: acc_q, too_few_electrons: 1'b0};
      end
      OP_EMIT_ZERO: begin
        res_q <= '{state_count: '0, too_few_electrons: 1'b0};
      end
      OP_EMIT_FLAG: begin
        res_q <= '{state_count: '0, too_few_electrons: 1'b1};
      end
      default: begin
      end
    endcase
  end

  // Strobe the result for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (op_i == OP_EMIT) || (op_i == OP_EMIT_ZERO) ||
                     (op_i == OP_EMIT_FLAG);
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: rtl/ocs_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on ocs_pkg.
module ocs_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  ocs_pkg::ocs_stat_t  stat_i,
  output ocs_pkg::ocs_op_e    op_o,
  output logic                busy_o
);
  import ocs_pkg::*;

  logic [PcW-1:0] pc_q, pc_d;
  logic           busy_q, busy_d;
  ocs_word_t      word;
  logic           take;

  assign word = ucode(pc_q);

  // Evaluate the jump condition
  always_comb begin
    case (word.cond)
      C_NEVER:  take = 1'b0;
      C_ALWAYS: take = 1'b1;
      C_FEW:    take = stat_i.few;
      C_BIG:    take = stat_i.big;
      C_RGTN:   take = stat_i.r_gt_n;
      C_IDONE:  take = stat_i.i_done;
      C_DBUSY:  take = stat_i.div_busy;
      C_MORE:   take = stat_i.more;
      default:  take = 1'b0;
    endcase
  end

  // Advance, jump or finish
  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (busy_q) begin
      if (word.cond == C_END) begin
        busy_d = 1'b0;
        pc_d   = P_CHK_FEW;
      end else begin
        pc_d = take ? word.target : pc_q + 1'b1;
      end
    end else if (accept_i) begin
      busy_d = 1'b1;
      pc_d   = P_CHK_FEW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= P_CHK_FEW;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

  // Drive the datapath only while running
  assign op_o   = busy_q ? word.op : OP_NOP;
  assign busy_o = busy_q;

endmodule

// File: rtl/occupation_state_counter.sv
// Occupation state counter: C(s,d) * C(s-d,u-d) * C(s-u,w-d) by exact multiply-then-divide.
// The product runs over F factors, F = sum of min(r, n-r) over the three terms (at most 48);
// each factor is multiplied into the accumulator and then divided out by the serial divider.
// One word at a time: busy stays high until the result is issued. Reset: asynchronous,
// active low; clears the sequencer, divider control, strobe and site_count (to 0).
// Depends on ocs_pkg, ocs_seq, ocs_dpath and ocs_div.
module occupation_state_counter #(
  parameter int unsigned MAX_SITES = ocs_pkg::MaxSitesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  ocs_pkg::ocs_in_t              cmd_i,
  output logic                          res_valid_o,
  output ocs_pkg::ocs_out_t             res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ocs_pkg::ApbAddrW-1:0]  paddr,
  input  logic [ocs_pkg::ApbDataW-1:0]  pwdata,
  output logic [ocs_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import ocs_pkg::*;

  logic [SiteW-1:0] site_q;
  logic             accept;
  logic             busy_int;
  ocs_op_e          op;
  ocs_stat_t        stat;

  assign accept = start && !busy_int;
  assign busy   = busy_int;
  assign pready = 1'b1;

  // Write the site count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      site_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegSiteCount)) begin
      site_q <= pwdata[SiteW-1:0];
    end
  end

  // Read back
  assign prdata = (paddr[2] == RegSiteCount) ? ApbDataW'(site_q) : '0;

  ocs_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .stat_i  (stat),
    .op_o    (op),
    .busy_o  (busy_int)
  );

  ocs_dpath #(
    .MAX_SITES(MAX_SITES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .cmd_i       (cmd_i),
    .site_count_i(site_q),
    .op_i        (op),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

// File: rtl/ocs_chk.sv
// Port-level checker for the occupation state counter, bound to the top level.
// Depends on ocs_pkg and occupation_state_counter.
module ocs_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              res_valid_o,
  input ocs_pkg::ocs_out_t res_o
);
  import ocs_pkg::*;

  // An accepted word makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  // Busy ends exactly when the result is issued
  a_fall_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o)
    else $error("busy dropped without a result");

  // A result is never issued while still working
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result issued while busy");

  // The strobe lasts one cycle
  a_strobe_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe longer than one cycle");

  // Too few electrons gives a zero count
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.too_few_electrons |-> res_o.state_count == '0)
    else $error("flagged result with nonzero count");

endmodule

bind occupation_state_counter ocs_chk u_ocs_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);

// File: tb/tb.sv
// Self-checking testbench for occupation_state_counter: directed and random words with checks.
// Depends on ocs_pkg and the occupation_state_counter RTL; needs no other files.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ocs_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainCycles = 100;
  localparam logic [ApbAddrW-1:0] SiteCountAddr = {RegSiteCount, 2'b00};

  typedef struct {
    ocs_in_t  word;
    ocs_out_t res;
  } pending_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  ocs_in_t             cmd_i;
  logic                res_valid_o;
  ocs_out_t            res_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // Model copy of the site count register and the counts still owed by the block
  logic [SiteW-1:0] site_reg;
  pending_t         pending_counts[$];
  pending_t         oldest;

  int unsigned sender_idle_pct;
  int unsigned stall_cycles;
  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned flagged_words;
  int unsigned empty_words;
  int unsigned nonzero_words;
  int unsigned site_writes;

  occupation_state_counter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Exact binomial coefficient from one row of Pascal's triangle
  function automatic logic [DataW-1:0] choose(input int unsigned n, input int unsigned r);
    logic [DataW-1:0] row [0:63];
    if (r > n) return '0;
    for (int i = 0; i < 64; i++) row[i] = '0;
    row[0] = 64'd1;
    for (int i = 1; i <= n; i++) begin
      for (int j = i; j >= 1; j--) row[j] = row[j] + row[j-1];
    end
    return row[r];
  endfunction

  // Number of lattice states for one word under the given site count
  function automatic ocs_out_t count_states(input ocs_in_t w, input logic [SiteW-1:0] sites);
    int unsigned s, d, u, v;
    ocs_out_t res;
    s = sites;
    if (s > MaxSitesDef) s = MaxSitesDef;
    d = w.double_count;
    u = w.up_count;
    v = w.down_count;
    res.state_count = '0;
    res.too_few_electrons = 1'b0;
    if (u < d || v < d) begin
      res.too_few_electrons = 1'b1;
    end else if (d <= s && u <= s) begin
      res.state_count = choose(s, d) * choose(s - d, u - d) * choose(s - u, v - d);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Lower start ahead of anything that is not a back-to-back word
  task automatic drop_start();
    if (start) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Hold the sender until every owed count has come back and the block is idle
  task automatic wait_drained();
    drop_start();
    while (pending_counts.size() != 0 || busy) @(posedge clk_i);
  endtask

  // Write the site count register through the APB port
  task automatic write_sites(input logic [ApbDataW-1:0] value);
    wait_drained();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SiteCountAddr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    site_reg = value[SiteW-1:0];
    site_writes++;
  endtask

  // Offer one word and wait for the block to take it
  task automatic send_word(input ocs_in_t w);
    int unsigned gap;
    pending_t entry;
    gap = 0;
    while (sender_idle_pct != 0 && gap < 60 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      drop_start();
      repeat (gap - 1) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= w;
    do @(posedge clk_i); while (busy);
    entry.word = w;
    entry.res  = count_states(w, site_reg);
    pending_counts = {pending_counts, entry};
    words_sent++;
    if (entry.res.too_few_electrons) flagged_words++;
    else if (entry.res.state_count == 0) empty_words++;
    else nonzero_words++;
  endtask

  task automatic send_fields(input int unsigned d, input int unsigned u, input int unsigned v);
    ocs_in_t w;
    w.double_count = d[SiteW-1:0];
    w.up_count     = u[SiteW-1:0];
    w.down_count   = v[SiteW-1:0];
    send_word(w);
  endtask

  // Full lattice: extremes, both zero cases and the electron shortage flag
  task automatic test_full_lattice();
    write_sites(32'd32);
    send_fields(0, 0, 0);
    send_fields(32, 32, 32);
    send_fields(0, 16, 16);
    send_fields(8, 16, 16);
    send_fields(10, 21, 21);
    send_fields(1, 32, 1);
    send_fields(0, 32, 32);
    send_fields(0, 0, 63);
    send_fields(63, 63, 63);
    send_fields(0, 63, 0);
    send_fields(5, 3, 10);
    send_fields(5, 10, 3);
    send_fields(42, 21, 21);
    send_fields(21, 42, 42);
  endtask

  // Empty lattice: only the all-zero word has a state
  task automatic test_empty_lattice();
    write_sites(32'd0);
    send_fields(0, 0, 0);
    send_fields(0, 1, 0);
    send_fields(1, 0, 0);
    send_fields(0, 0, 1);
  endtask

  // Site count above the maximum saturates
  task automatic test_saturated_sites();
    write_sites(32'd63);
    send_fields(16, 16, 16);
    send_fields(0, 32, 0);
    send_fields(16, 24, 24);
    send_fields(33, 33, 33);
  endtask

  // Mostly well-formed occupations with random content, plus noise and broken words
  task automatic test_random_mix(input int unsigned n_words, input logic [SiteW-1:0] sites,
                                 input int unsigned idle_pct, input bit pause_midway);
    int unsigned eff, d, u, v, pick;
    write_sites({$urandom} & ~32'h3f | {26'd0, sites});
    sender_idle_pct = idle_pct;
    eff = (sites > MaxSitesDef) ? MaxSitesDef : sites;
    for (int i = 0; i < n_words; i++) begin
      if (pause_midway && i == n_words / 2) wait_drained();
      pick = $urandom_range(99);
      d = $urandom_range(eff, 0);
      u = $urandom_range(eff, d);
      v = $urandom_range(d + eff - u, d);
      if (pick < 10) begin
        d = $urandom_range(63, 0);
        u = $urandom_range(63, 0);
        v = $urandom_range(63, 0);
      end else if (pick < 15) begin
        v = v + $urandom_range(3, 1);
      end else if (pick < 20) begin
        d = d + $urandom_range(3, 1);
      end
      send_fields(d, u, v);
    end
  endtask

  // Compare each result against the oldest owed count
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (pending_counts.size() == 0) begin
        report_mismatch($sformatf("unexpected result: count %0d flag %0b",
                                  res_o.state_count, res_o.too_few_electrons));
      end else begin
        oldest = pending_counts.pop_front();
        if (res_o.state_count !== oldest.res.state_count)
          report_mismatch($sformatf("d=%0d u=%0d w=%0d: state_count %0d, want %0d",
                                    oldest.word.double_count, oldest.word.up_count,
                                    oldest.word.down_count, res_o.state_count,
                                    oldest.res.state_count));
        if (res_o.too_few_electrons !== oldest.res.too_few_electrons)
          report_mismatch($sformatf("d=%0d u=%0d w=%0d: too_few_electrons %0b, want %0b",
                                    oldest.word.double_count, oldest.word.up_count,
                                    oldest.word.down_count, res_o.too_few_electrons,
                                    oldest.res.too_few_electrons));
      end
    end
  end

  // Watchdog: end the run after too long without any accepted word, result or register write
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o || (psel && penable && pwrite && pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("timeout after %0d idle cycles, %0d counts owed", stall_cycles,
               pending_counts.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    start           <= 1'b0;
    cmd_i           <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    site_reg         = '0;
    words_sent       = 0;
    flagged_words    = 0;
    empty_words      = 0;
    nonzero_words    = 0;
    site_writes      = 0;
    sender_idle_pct  = 36;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_full_lattice();
    test_empty_lattice();
    test_saturated_sites();
    test_random_mix(50, 6'd20, 36, 1'b0);
    test_random_mix(45, 6'd7, 88, 1'b1);
    test_random_mix(35, 6'd32, 0, 1'b0);
    test_random_mix(25, 6'd45, 0, 1'b0);

    // Let any stray result show up before judging
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("sent %0d words over %0d site count writes", words_sent, site_writes);
    $display("%0d short of electrons, %0d with no states, %0d with states",
             flagged_words, empty_words, nonzero_words);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
